// ===== sv/ray_circle_nearest_hit_defines.svh =====
// ----------------------------------------------------------------------------
// ray_circle_nearest_hit_defines
// assertion macros shared by the ray circle nearest hit rtl
// ----------------------------------------------------------------------------
`ifndef RAY_CIRCLE_NEAREST_HIT_DEFINES_SVH
`define RAY_CIRCLE_NEAREST_HIT_DEFINES_SVH

// same cycle implication under the active low reset
`define RCNH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next cycle implication under the active low reset
`define RCNH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rcnh_pkg.sv =====
// ----------------------------------------------------------------------------
// rcnh_pkg
// types and constants of the ray circle nearest hit block
// ----------------------------------------------------------------------------
`default_nettype none

package rcnh_pkg;

    localparam int ID_BITS_DEF = 16;
    // direction is q1.14
    localparam int DIR_SHIFT   = 14;
    // root bits of the square root, two radicand bits per step
    localparam int SQRT_STEPS  = 52;
    localparam int ACC_W       = 2 * SQRT_STEPS;
    localparam int DIV_STEPS   = 64;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_CAND   = 2'd1,
        OP_FINISH = 2'd2
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_ACC,
        S_CHECK,
        S_SQRT,
        S_NUM,
        S_DIV,
        S_UPDATE
    } state_t;

    // multiply steps of the shared multiplier, run in this order
    typedef enum logic [3:0] {
        U_HX  = 4'd0,
        U_HY  = 4'd1,
        U_AX  = 4'd2,
        U_AY  = 4'd3,
        U_SX  = 4'd4,
        U_SY  = 4'd5,
        U_RR  = 4'd6,
        U_HLL = 4'd7,
        U_HLH = 4'd8,
        U_HHH = 4'd9,
        U_ARL = 4'd10,
        U_ARH = 4'd11,
        U_AS0 = 4'd12,
        U_AS1 = 4'd13,
        U_AS2 = 4'd14
    } uop_t;

endpackage

`default_nettype wire

// ===== sv/ray_circle_nearest_hit.sv =====
// ----------------------------------------------------------------------------
// ray_circle_nearest_hit
// nearest circle hit along a ray in q16.16 fixed point
// ----------------------------------------------------------------------------
// A begin request loads the ray and clears the best hit, a candidate request
// tests one circle, and a finish request emits one result (hit flag, distance
// clamped at zero, hit id). Begin, finish, unused opcodes and candidates that
// carry the own id leave the block idle. Any other candidate keeps it busy
// through the prep step, 15 products on the shared 32x32 multiplier (each a
// multiply and an accumulate step), the check, 52 square root steps, the
// numerator step, 64 restoring divide steps and the update. A candidate with
// a zero direction or a negative discriminant returns to idle after the check.
// A finish request waits while busy or while an earlier result is not taken.
`default_nettype none

`include "ray_circle_nearest_hit_defines.svh"

module ray_circle_nearest_hit #(
    parameter int ID_BITS = rcnh_pkg::ID_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire logic [1:0]            opcode,
    input  wire logic signed [31:0]    point_x,
    input  wire logic signed [31:0]    point_y,
    input  wire logic signed [15:0]    dir_x,
    input  wire logic signed [15:0]    dir_y,
    input  wire logic [30:0]           near_limit,
    input  wire logic [30:0]           reach,
    input  wire logic [30:0]           radius,
    input  wire logic [ID_BITS-1:0]    entity_id,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic                       hit,
    output logic [30:0]                hit_distance,
    output logic [ID_BITS-1:0]         hit_id
);

    localparam int ACC_W  = rcnh_pkg::ACC_W;
    localparam int ROOT_W = rcnh_pkg::SQRT_STEPS;
    localparam int REM_W  = ROOT_W + 4;
    localparam int CNT_W  = $clog2(rcnh_pkg::DIV_STEPS);

    // sequencer
    rcnh_pkg::state_t state_reg, state_next;
    rcnh_pkg::uop_t   uop_reg;
    logic [CNT_W-1:0] iter_reg;

    // ray state
    logic [31:0]         start_x_reg, start_y_reg;
    logic [15:0]         dir_x_reg, dir_y_reg;
    logic [30:0]         back_reg;
    logic [31:0]         best_reg;
    logic [ID_BITS-1:0]  best_id_reg, own_id_reg;
    logic                found_reg;

    // candidate working registers
    logic [32:0]         wx_reg, wy_reg;
    logic [31:0]         ax_reg, ay_reg;
    logic [30:0]         radius_reg;
    logic [ID_BITS-1:0]  cand_id_reg;
    logic [63:0]         prod_reg;
    logic [31:0]         a_reg;
    logic [65:0]         s_reg;
    logic [61:0]         r2_reg;
    logic [48:0]         habs_reg;
    logic                h_neg_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    radicand_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic                neg_reg;
    logic [63:0]         dvd_reg;
    logic [32:0]         drem_reg;

    // result register
    logic                res_valid_reg, res_hit_reg;
    logic [30:0]         res_dist_reg;
    logic [ID_BITS-1:0]  res_id_reg;

    logic req_fire;
    assign req_fire = req_valid && req_ready;

    // direction magnitudes
    logic [16:0] dxm, dym;
    assign dxm = dir_x_reg[15] ? 17'(~{dir_x_reg[15], dir_x_reg} + 17'd1) : {1'b0, dir_x_reg};
    assign dym = dir_y_reg[15] ? 17'(~{dir_y_reg[15], dir_y_reg} + 17'd1) : {1'b0, dir_y_reg};

    // shared multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] hl, hh;
    assign hl = habs_reg[31:0];
    assign hh = {15'd0, habs_reg[48:32]};

    always_comb
    begin
        case (uop_reg)
            rcnh_pkg::U_HX:  begin mul_a = 32'(dxm);    mul_b = ax_reg; end
            rcnh_pkg::U_HY:  begin mul_a = 32'(dym);    mul_b = ay_reg; end
            rcnh_pkg::U_AX:  begin mul_a = 32'(dxm);    mul_b = 32'(dxm); end
            rcnh_pkg::U_AY:  begin mul_a = 32'(dym);    mul_b = 32'(dym); end
            rcnh_pkg::U_SX:  begin mul_a = ax_reg;      mul_b = ax_reg; end
            rcnh_pkg::U_SY:  begin mul_a = ay_reg;      mul_b = ay_reg; end
            rcnh_pkg::U_RR:  begin mul_a = {1'b0, radius_reg}; mul_b = {1'b0, radius_reg}; end
            rcnh_pkg::U_HLL: begin mul_a = hl;          mul_b = hl; end
            rcnh_pkg::U_HLH: begin mul_a = hl;          mul_b = hh; end
            rcnh_pkg::U_HHH: begin mul_a = hh;          mul_b = hh; end
            rcnh_pkg::U_ARL: begin mul_a = a_reg;       mul_b = r2_reg[31:0]; end
            rcnh_pkg::U_ARH: begin mul_a = a_reg;       mul_b = {2'd0, r2_reg[61:32]}; end
            rcnh_pkg::U_AS0: begin mul_a = a_reg;       mul_b = s_reg[31:0]; end
            rcnh_pkg::U_AS1: begin mul_a = a_reg;       mul_b = s_reg[63:32]; end
            default:         begin mul_a = a_reg;       mul_b = {30'd0, s_reg[65:64]}; end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // accumulator term: the cross term of h^2 counts twice, hence the shift by 33
    logic [ACC_W-1:0] term, acc_next, acc_mag;
    logic             term_sub, term_set;

    always_comb
    begin
        case (uop_reg)
            rcnh_pkg::U_HLH:                  term = ACC_W'(prod_reg) << 33;
            rcnh_pkg::U_ARH, rcnh_pkg::U_AS1: term = ACC_W'(prod_reg) << 32;
            rcnh_pkg::U_HHH, rcnh_pkg::U_AS2: term = ACC_W'(prod_reg) << 64;
            default:                          term = ACC_W'(prod_reg);
        endcase
        term_set = (uop_reg == rcnh_pkg::U_HX) || (uop_reg == rcnh_pkg::U_HLL);
        term_sub = ((uop_reg == rcnh_pkg::U_HX) && (dir_x_reg[15] ^ wx_reg[32]))
                || ((uop_reg == rcnh_pkg::U_HY) && (dir_y_reg[15] ^ wy_reg[32]))
                || (uop_reg == rcnh_pkg::U_AS0) || (uop_reg == rcnh_pkg::U_AS1)
                || (uop_reg == rcnh_pkg::U_AS2);
        acc_next = (term_set ? '0 : acc_reg) + (term_sub ? (~term + 1'b1) : term);
        acc_mag  = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
    end

    // square root step
    logic [REM_W-1:0] rem_t, trial;
    logic             sq_ge;
    assign rem_t = {rem_reg[REM_W-3:0], radicand_reg[ACC_W-1 -: 2]};
    assign trial = REM_W'({root_reg, 2'b01});
    assign sq_ge = rem_t >= trial;

    // numerator -h - sqrt as sign and magnitude
    logic [52:0] habs_ext, sq_ext, num;
    logic        num_neg;
    always_comb
    begin
        habs_ext = 53'(habs_reg);
        sq_ext   = 53'(root_reg);
        if (!h_neg_reg)
        begin
            num_neg = 1'b1;
            num     = habs_ext + sq_ext;
        end
        else if (habs_ext >= sq_ext)
        begin
            num_neg = 1'b0;
            num     = habs_ext - sq_ext;
        end
        else
        begin
            num_neg = 1'b1;
            num     = sq_ext - habs_ext;
        end
    end

    // divide step
    logic [32:0] drem_t;
    logic        dv_ge;
    assign drem_t = {drem_reg[31:0], dvd_reg[63]};
    assign dv_ge  = drem_t >= {1'b0, a_reg};

    // distance check against back limit and best so far
    logic        in_range, closer;
    logic [33:0] t_val;
    always_comb
    begin
        if (neg_reg)
        begin
            in_range = dvd_reg <= 64'(back_reg);
            t_val    = 34'd0 - {2'd0, dvd_reg[31:0]};
        end
        else
        begin
            in_range = dvd_reg[63:32] == 32'd0;
            t_val    = {2'd0, dvd_reg[31:0]};
        end
        closer = $signed(t_val) < $signed({{2{best_reg[31]}}, best_reg});
    end

    logic skip_cand;
    assign skip_cand = (a_reg == 32'd0) || acc_reg[ACC_W-1];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rcnh_pkg::S_IDLE:
            begin
                if (req_fire && (opcode == rcnh_pkg::OP_CAND) && (entity_id != own_id_reg))
                    state_next = rcnh_pkg::S_PREP;
            end
            rcnh_pkg::S_PREP:  state_next = rcnh_pkg::S_MUL;
            rcnh_pkg::S_MUL:   state_next = rcnh_pkg::S_ACC;
            rcnh_pkg::S_ACC:
            begin
                state_next = (uop_reg == rcnh_pkg::U_AS2) ? rcnh_pkg::S_CHECK
                                                          : rcnh_pkg::S_MUL;
            end
            rcnh_pkg::S_CHECK:
            begin
                state_next = skip_cand ? rcnh_pkg::S_IDLE : rcnh_pkg::S_SQRT;
            end
            rcnh_pkg::S_SQRT:
            begin
                if (iter_reg == CNT_W'(rcnh_pkg::SQRT_STEPS - 1))
                    state_next = rcnh_pkg::S_NUM;
            end
            rcnh_pkg::S_NUM:   state_next = rcnh_pkg::S_DIV;
            rcnh_pkg::S_DIV:
            begin
                if (iter_reg == CNT_W'(rcnh_pkg::DIV_STEPS - 1))
                    state_next = rcnh_pkg::S_UPDATE;
            end
            rcnh_pkg::S_UPDATE: state_next = rcnh_pkg::S_IDLE;
            default:            state_next = rcnh_pkg::S_IDLE;
        endcase
    end

    // handshake outputs: requests wait while busy, a finish also for a free result register
    always_comb
    begin
        req_ready = (state_reg == rcnh_pkg::S_IDLE)
                 && ((opcode != rcnh_pkg::OP_FINISH) || !res_valid_reg || res_ready);
    end

    assign res_valid    = res_valid_reg;
    assign hit          = res_hit_reg;
    assign hit_distance = res_dist_reg;
    assign hit_id       = res_id_reg;

    // control and ray state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcnh_pkg::S_IDLE;
            uop_reg       <= rcnh_pkg::U_HX;
            iter_reg      <= '0;
            res_valid_reg <= 1'b0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            dir_x_reg     <= '0;
            dir_y_reg     <= '0;
            back_reg      <= '0;
            best_reg      <= '0;
            best_id_reg   <= '0;
            own_id_reg    <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // a new finish refills the result register as the old one leaves
            if (req_fire && (opcode == rcnh_pkg::OP_FINISH))
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                rcnh_pkg::S_IDLE:
                begin
                    if (req_fire && (opcode == rcnh_pkg::OP_BEGIN))
                    begin
                        start_x_reg <= point_x;
                        start_y_reg <= point_y;
                        dir_x_reg   <= dir_x;
                        dir_y_reg   <= dir_y;
                        back_reg    <= near_limit;
                        best_reg    <= {1'b0, reach};
                        own_id_reg  <= entity_id;
                        best_id_reg <= '0;
                        found_reg   <= 1'b0;
                    end
                end
                rcnh_pkg::S_PREP: uop_reg <= rcnh_pkg::U_HX;
                rcnh_pkg::S_ACC:
                begin
                    if (uop_reg != rcnh_pkg::U_AS2)
                        uop_reg <= rcnh_pkg::uop_t'(uop_reg + 4'd1);
                end
                rcnh_pkg::S_CHECK: iter_reg <= '0;
                rcnh_pkg::S_SQRT:  iter_reg <= iter_reg + 1'b1;
                rcnh_pkg::S_NUM:   iter_reg <= '0;
                rcnh_pkg::S_DIV:   iter_reg <= iter_reg + 1'b1;
                rcnh_pkg::S_UPDATE:
                begin
                    if (in_range && closer)
                    begin
                        best_reg    <= t_val[31:0];
                        best_id_reg <= cand_id_reg;
                        found_reg   <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rcnh_pkg::S_IDLE:
            begin
                if (req_fire && (opcode == rcnh_pkg::OP_CAND))
                begin
                    wx_reg      <= {start_x_reg[31], start_x_reg} - {point_x[31], point_x};
                    wy_reg      <= {start_y_reg[31], start_y_reg} - {point_y[31], point_y};
                    radius_reg  <= radius;
                    cand_id_reg <= entity_id;
                end
                if (req_fire && (opcode == rcnh_pkg::OP_FINISH))
                begin
                    res_hit_reg  <= found_reg;
                    res_dist_reg <= best_reg[31] ? 31'd0 : best_reg[30:0];
                    res_id_reg   <= found_reg ? best_id_reg : '0;
                end
            end
            rcnh_pkg::S_PREP:
            begin
                ax_reg <= wx_reg[32] ? 32'(~wx_reg + 33'd1) : wx_reg[31:0];
                ay_reg <= wy_reg[32] ? 32'(~wy_reg + 33'd1) : wy_reg[31:0];
            end
            rcnh_pkg::S_MUL: prod_reg <= mul_p;
            rcnh_pkg::S_ACC:
            begin
                case (uop_reg)
                    rcnh_pkg::U_AX:
                    begin
                        // h is complete in the accumulator here
                        a_reg     <= prod_reg[31:0];
                        habs_reg  <= acc_mag[48:0];
                        h_neg_reg <= acc_reg[ACC_W-1];
                    end
                    rcnh_pkg::U_AY: a_reg  <= a_reg + prod_reg[31:0];
                    rcnh_pkg::U_SX: s_reg  <= 66'(prod_reg);
                    rcnh_pkg::U_SY: s_reg  <= s_reg + 66'(prod_reg);
                    rcnh_pkg::U_RR: r2_reg <= prod_reg[61:0];
                    default:        acc_reg <= acc_next;
                endcase
            end
            rcnh_pkg::S_CHECK:
            begin
                radicand_reg <= acc_reg;
                rem_reg      <= '0;
                root_reg     <= '0;
            end
            rcnh_pkg::S_SQRT:
            begin
                rem_reg      <= sq_ge ? (rem_t - trial) : rem_t;
                root_reg     <= {root_reg[ROOT_W-2:0], sq_ge};
                radicand_reg <= radicand_reg << 2;
            end
            rcnh_pkg::S_NUM:
            begin
                neg_reg  <= num_neg;
                dvd_reg  <= 64'(num) << rcnh_pkg::DIR_SHIFT;
                drem_reg <= '0;
            end
            rcnh_pkg::S_DIV:
            begin
                drem_reg <= dv_ge ? (drem_t - {1'b0, a_reg}) : drem_t;
                dvd_reg  <= {dvd_reg[62:0], dv_ge};
            end
            default: ;
        endcase
    end

    // checks
    `RCNH_ASSERT_NOW(a_ready_idle, req_ready, state_reg == rcnh_pkg::S_IDLE, "ready while busy")
    `RCNH_ASSERT_NEXT(a_begin_clears, req_fire && (opcode == rcnh_pkg::OP_BEGIN), !found_reg && (best_id_reg == '0), "begin did not clear best hit")
    `RCNH_ASSERT_NOW(a_sqrt_count, state_reg == rcnh_pkg::S_SQRT, iter_reg < CNT_W'(rcnh_pkg::SQRT_STEPS), "square root overran")
    `RCNH_ASSERT_NOW(a_miss_id, res_valid_reg && !res_hit_reg, res_id_reg == '0, "miss with nonzero id")

endmodule

`default_nettype wire
